// ----- hw/rtl/bsg_pkg.sv -----
// shared types and constants for the bounding sphere block
package bsg_pkg;

   localparam int unsigned CoordWidth  = 32;
   localparam int unsigned RadiusWidth = 33;
   localparam int unsigned DiffWidth   = 33;
   localparam int unsigned SumWidth    = 67;
   localparam int unsigned RootBits    = 34;
   localparam int unsigned ProdWidth   = 66;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_ACC,
      ST_ROOT,
      ST_CMP,
      ST_MUL,
      ST_DIV,
      ST_MOVE,
      ST_OUT
   } state_type;

endpackage

// ----- hw/rtl/bounding_sphere_grow.sv -----
// single-pass bounding sphere of a stream of fixed point points
//
//  channel | direction | handshake       | payload
//  req     | in        | req_valid/stall | point_x/y/z, first_point, last_point
//  rsp     | out       | rsp_valid/stall | sphere_radius, center_x/y/z
//
// a first point is taken alone, and goes on to load the result when it is also the last; any
// other point takes three square and add pairs, then a root (one bit a cycle), then a compare,
// and, when it lies outside, a multiply, a restoring divide and a move for each axis.
// a last point then loads the result. one shared multiplier does the squares and the
// multiplies; the root step and the divider have their own logic. one item at a time.
// reset is synchronous and clears the sphere to centre 0, radius 0.
// a result waits in the output register while rsp_stall is high; the next point is
// taken only once it has been transferred.
module bounding_sphere_grow (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_point_x,
   input  logic [31:0] req_point_y,
   input  logic [31:0] req_point_z,
   input  logic        req_first_point,
   input  logic        req_last_point,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [32:0] rsp_sphere_radius,
   output logic [31:0] rsp_center_x,
   output logic [31:0] rsp_center_y,
   output logic [31:0] rsp_center_z
);

   bsg_pkg::state_type state_ff, state_in;

   logic signed [31:0] cx_ff [3];
   logic signed [31:0] px_ff [3];
   logic [32:0]  radius_ff, rnew_ff;
   logic         last_ff;
   logic [1:0]   axis_ff;
   logic [66:0]  sum_ff;
   logic [65:0]  prod_ff;
   logic [33:0]  root_ff, dist_ff;
   logic [6:0]   cnt_ff;
   logic [67:0]  rem_ff;
   logic [65:0]  quo_ff;
   logic         out_valid_ff;

   logic signed [32:0] diff;
   logic [32:0]        dmag;
   logic [32:0]        mul_b;
   logic [65:0]        mul_p;
   logic [33:0]        cand;
   logic [67:0]        cand_sq;
   logic [67:0]        rem_sh;
   logic signed [33:0] moved;
   logic               accept;

   assign diff  = {cx_ff[axis_ff][31], cx_ff[axis_ff]} - {px_ff[axis_ff][31], px_ff[axis_ff]};
   assign dmag  = diff[32] ? 33'(-diff) : diff;
   // shared multiplier: squares during distance, times new radius during moves
   assign mul_b = (state_ff == bsg_pkg::ST_SQ) ? dmag : rnew_ff;
   assign mul_p = 66'(dmag) * 66'(mul_b);
   assign cand    = root_ff | (34'd1 << cnt_ff[5:0]);
   assign cand_sq = 68'(cand) * 68'(cand);
   assign rem_sh  = {rem_ff[66:0], prod_ff[65]};
   assign moved   = diff[32] ? ({{2{px_ff[axis_ff][31]}}, px_ff[axis_ff]} - 34'(quo_ff[32:0]))
                             : ({{2{px_ff[axis_ff][31]}}, px_ff[axis_ff]} + 34'(quo_ff[32:0]));

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != bsg_pkg::ST_IDLE) || out_valid_ff;
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsg_pkg::ST_IDLE: begin
            if (accept && !req_first_point) state_in = bsg_pkg::ST_SQ;
            else if (accept && req_last_point) state_in = bsg_pkg::ST_OUT;
         end
         bsg_pkg::ST_SQ:   state_in = bsg_pkg::ST_ACC;
         bsg_pkg::ST_ACC:  state_in = (axis_ff == 2'd2) ? bsg_pkg::ST_ROOT : bsg_pkg::ST_SQ;
         bsg_pkg::ST_ROOT: if (cnt_ff == 7'd0) state_in = bsg_pkg::ST_CMP;
         bsg_pkg::ST_CMP: begin
            if ({1'b0, radius_ff} < root_ff) state_in = bsg_pkg::ST_MUL;
            else if (last_ff) state_in = bsg_pkg::ST_OUT;
            else state_in = bsg_pkg::ST_IDLE;
         end
         bsg_pkg::ST_MUL:  state_in = bsg_pkg::ST_DIV;
         bsg_pkg::ST_DIV:  if (cnt_ff == 7'd0) state_in = bsg_pkg::ST_MOVE;
         bsg_pkg::ST_MOVE: begin
            if (axis_ff != 2'd2) state_in = bsg_pkg::ST_MUL;
            else if (last_ff) state_in = bsg_pkg::ST_OUT;
            else state_in = bsg_pkg::ST_IDLE;
         end
         bsg_pkg::ST_OUT:  state_in = bsg_pkg::ST_IDLE;
         default:          state_in = bsg_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsg_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
         radius_ff    <= '0;
         for (int i = 0; i < 3; i++) cx_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (out_valid_ff && !rsp_stall) out_valid_ff <= 1'b0;
         case (state_ff)
            bsg_pkg::ST_IDLE: begin
               if (accept) begin
                  px_ff[0] <= req_point_x;
                  px_ff[1] <= req_point_y;
                  px_ff[2] <= req_point_z;
                  last_ff  <= req_last_point;
                  axis_ff  <= 2'd0;
                  sum_ff   <= '0;
                  if (req_first_point) begin
                     cx_ff[0]  <= req_point_x;
                     cx_ff[1]  <= req_point_y;
                     cx_ff[2]  <= req_point_z;
                     radius_ff <= '0;
                  end
               end
            end
            bsg_pkg::ST_SQ:  prod_ff <= mul_p;
            bsg_pkg::ST_ACC: begin
               sum_ff  <= sum_ff + 67'(prod_ff);
               axis_ff <= axis_ff + 2'd1;
               root_ff <= '0;
               cnt_ff  <= 7'd33;
            end
            bsg_pkg::ST_ROOT: begin
               if (cand_sq <= {1'b0, sum_ff}) root_ff <= cand;
               cnt_ff <= cnt_ff - 7'd1;
            end
            bsg_pkg::ST_CMP: begin
               dist_ff <= root_ff;
               rnew_ff <= 33'(({1'b0, radius_ff} + root_ff) >> 1);
               axis_ff <= 2'd0;
            end
            bsg_pkg::ST_MUL: begin
               prod_ff <= mul_p;
               rem_ff  <= '0;
               cnt_ff  <= 7'd65;
            end
            bsg_pkg::ST_DIV: begin
               // restoring division, one quotient bit a cycle
               if (rem_sh >= 68'(dist_ff)) begin
                  rem_ff <= rem_sh - 68'(dist_ff);
                  quo_ff <= {quo_ff[64:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  quo_ff <= {quo_ff[64:0], 1'b0};
               end
               prod_ff <= {prod_ff[64:0], 1'b0};
               cnt_ff  <= cnt_ff - 7'd1;
            end
            bsg_pkg::ST_MOVE: begin
               cx_ff[axis_ff] <= moved[31:0];
               axis_ff        <= axis_ff + 2'd1;
               if (axis_ff == 2'd2) radius_ff <= rnew_ff;
            end
            bsg_pkg::ST_OUT: out_valid_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   assign rsp_sphere_radius = radius_ff;
   assign rsp_center_x      = cx_ff[0];
   assign rsp_center_y      = cx_ff[1];
   assign rsp_center_z      = cx_ff[2];

endmodule

// ----- hw/rtl/bsg_checker.sv -----
// port-level checks for the bounding sphere block
module bsg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_first_point,
   input logic        req_last_point,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [32:0] rsp_sphere_radius
);

   // after any point but a first point that is not also the last, req_stall is high in the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !(req_first_point && !req_last_point) |=> req_stall)
      else $error("took two points back to back");

   a_busy_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("point taken while result pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sphere_radius))
      else $error("stalled result changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result valid after reset");

endmodule

bind bounding_sphere_grow bsg_checker u_bsg_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_first_point(req_first_point), .req_last_point(req_last_point),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_sphere_radius(rsp_sphere_radius)
);
